@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. All checks use the block clock and
// are disabled while the asynchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check on clk_i, off during reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true on a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/bcdc_pkg.sv @@
`timescale 1ns / 1ps
package bcdc_pkg;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  // key codes
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_UP        = 4'd10;
  localparam logic [3:0] KEY_DOWN      = 4'd11;
  localparam logic [3:0] KEY_SET       = 4'd15;

  // cursor positions
  localparam logic [2:0] CUR_SEC_U  = 3'd0;
  localparam logic [2:0] CUR_SEC_T  = 3'd1;
  localparam logic [2:0] CUR_MIN_U  = 3'd2;
  localparam logic [2:0] CUR_MIN_T  = 3'd3;
  localparam logic [2:0] CUR_HOUR_U = 3'd4;
  localparam logic [2:0] CUR_HOUR_T = 3'd5;

  // digit limits
  localparam logic [3:0] UNITS_MAX     = 4'd9;
  localparam logic [2:0] TENS_MAX      = 3'd5;
  localparam logic [1:0] HOUR_T_MAX    = 2'd2;
  localparam logic [3:0] HOUR_U_MAX_20 = 4'd3;

  // register map
  localparam logic       REG_TPS   = 1'b0;
  localparam logic [7:0] TPS_RESET = 8'd20;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] min_tens;
    logic [3:0] min_units;
    logic [2:0] sec_tens;
    logic [3:0] sec_units;
  } time_t;

  typedef struct packed {
    time_t      digits;
    logic [2:0] cursor;
    logic       setting;
  } edit_t;

  typedef struct packed {
    logic       operation;
    logic [3:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic [3:0] sec_units;
    logic [2:0] sec_tens;
    logic [3:0] min_units;
    logic [2:0] min_tens;
    logic [3:0] hour_units;
    logic [1:0] hour_tens;
    logic [2:0] cursor_pos;
    logic       setting_mode;
    logic       second_elapsed;
  } out_item_t;

endpackage

@@ rtl/bcdc_cfg_regs.sv @@
`timescale 1ns / 1ps
module bcdc_cfg_regs import bcdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  tps_o
);

  logic [7:0] tps_q, tps_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TPS);

  always_comb begin
    tps_d = wr_en ? pwdata[7:0] : tps_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else begin
      tps_q <= tps_d;
    end
  end

  // unused word reads as zero; byte lanes ignored
  assign prdata = (paddr[2] == REG_TPS) ? {24'd0, tps_q} : 32'd0;
  assign tps_o  = tps_q;

endmodule

@@ rtl/bcdc_advance.sv @@
`timescale 1ns / 1ps
module bcdc_advance import bcdc_pkg::*; (
  input  time_t cur_i,
  output time_t nxt_o
);

  logic [3:0] su_inc, mu_inc, hu_inc, hu_n;
  logic [2:0] st_inc, mt_inc;
  logic [1:0] ht_n;

  assign su_inc = cur_i.sec_units + 4'd1;
  assign st_inc = cur_i.sec_tens + 3'd1;
  assign mu_inc = cur_i.min_units + 4'd1;
  assign mt_inc = cur_i.min_tens + 3'd1;
  assign hu_inc = cur_i.hour_units + 4'd1;

  // hours: 09 -> 10, 19 -> 20, 23 -> 00
  always_comb begin
    hu_n = hu_inc;
    ht_n = cur_i.hour_tens;
    if (hu_inc > UNITS_MAX && cur_i.hour_tens < HOUR_T_MAX) begin
      ht_n = cur_i.hour_tens + 2'd1;
      hu_n = 4'd0;
    end
    if (hu_n > HOUR_U_MAX_20 && ht_n >= HOUR_T_MAX) begin
      ht_n = 2'd0;
      hu_n = 4'd0;
    end
  end

  always_comb begin
    nxt_o = cur_i;
    if (su_inc <= UNITS_MAX) begin
      nxt_o.sec_units = su_inc;
    end else begin
      nxt_o.sec_units = 4'd0;
      if (st_inc <= TENS_MAX) begin
        nxt_o.sec_tens = st_inc;
      end else begin
        nxt_o.sec_tens = 3'd0;
        if (mu_inc <= UNITS_MAX) begin
          nxt_o.min_units = mu_inc;
        end else begin
          nxt_o.min_units = 4'd0;
          if (mt_inc <= TENS_MAX) begin
            nxt_o.min_tens = mt_inc;
          end else begin
            nxt_o.min_tens   = 3'd0;
            nxt_o.hour_units = hu_n;
            nxt_o.hour_tens  = ht_n;
          end
        end
      end
    end
  end

endmodule

@@ rtl/bcdc_editor.sv @@
`timescale 1ns / 1ps
module bcdc_editor import bcdc_pkg::*; (
  input  edit_t      cur_i,
  input  logic [3:0] key_i,
  output edit_t      nxt_o
);

  logic [2:0] cur_dn, cur_up;
  logic [2:0] tens_clamp;
  logic [3:0] hu_wr;
  logic [1:0] ht_wr;

  assign cur_dn = (cur_i.cursor == CUR_SEC_U) ? CUR_HOUR_T : cur_i.cursor - 3'd1;
  assign cur_up = (cur_i.cursor >= CUR_HOUR_T) ? CUR_SEC_U : cur_i.cursor + 3'd1;

  assign tens_clamp = (key_i > 4'(TENS_MAX)) ? TENS_MAX : key_i[2:0];

  assign hu_wr = (cur_i.digits.hour_tens == HOUR_T_MAX && key_i > HOUR_U_MAX_20) ?
                 HOUR_U_MAX_20 : key_i;

  // hour tens: keep 20-23 legal against the units digit already set
  always_comb begin
    if (key_i < 4'd3) begin
      ht_wr = (cur_i.digits.hour_units > HOUR_U_MAX_20 && key_i == 4'd2) ?
              2'd1 : key_i[1:0];
    end else begin
      ht_wr = (cur_i.digits.hour_units <= HOUR_U_MAX_20) ? HOUR_T_MAX : 2'd1;
    end
  end

  always_comb begin
    nxt_o = cur_i;
    if (!cur_i.setting) begin
      if (key_i == KEY_SET) begin
        nxt_o.setting = 1'b1;
        nxt_o.cursor  = CUR_HOUR_T;
      end
    end else if (key_i <= KEY_DIGIT_MAX) begin
      unique case (cur_i.cursor)
        CUR_SEC_U:  nxt_o.digits.sec_units  = key_i;
        CUR_SEC_T:  nxt_o.digits.sec_tens   = tens_clamp;
        CUR_MIN_U:  nxt_o.digits.min_units  = key_i;
        CUR_MIN_T:  nxt_o.digits.min_tens   = tens_clamp;
        CUR_HOUR_U: nxt_o.digits.hour_units = hu_wr;
        CUR_HOUR_T: nxt_o.digits.hour_tens  = ht_wr;
        default:    nxt_o.digits = cur_i.digits;
      endcase
      nxt_o.cursor = cur_dn;
    end else if (key_i == KEY_DOWN) begin
      nxt_o.cursor = cur_dn;
    end else if (key_i == KEY_UP) begin
      nxt_o.cursor = cur_up;
    end else if (key_i == KEY_SET) begin
      nxt_o.setting = 1'b0;
    end
  end

endmodule

@@ rtl/bcd_clock_with_digit_setting.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake                    payload
// in        input      in_valid_i / in_ready_o      in_item_i  (in_item_t)
// out       output     out_valid_o / out_ready_i    out_item_o (out_item_t)
// cfg       input      psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One item per cycle while in_ready_o is high; its result shows in the cycle after acceptance.
// The whole update (prescaler, six-digit carry chain or key edit) is
// one combinational pass from the state registers into the result register.
// in_ready_o drops only while a result is held and out_ready_i is low.
// Reset clears the time to 00:00:00, cursor to hours tens, clock running,
// ticks_per_second to 20. No clearing pass after reset.
`include "assert_macros.svh"
module bcd_clock_with_digit_setting import bcdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // clock state
  time_t      time_q, time_d;
  logic [7:0] tick_q, tick_d;
  logic [2:0] cursor_q, cursor_d;
  logic       setting_q, setting_d;

  // result register
  out_item_t  out_q, out_d;
  logic       out_valid_q, out_valid_d;

  logic       accept;
  logic [7:0] tps;
  logic [7:0] tick_inc;
  logic       sec_hit;
  time_t      time_adv;
  edit_t      edit_cur, edit_nxt;

  bcdc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tps_o   (tps)
  );

  bcdc_advance u_adv (
    .cur_i (time_q),
    .nxt_o (time_adv)
  );

  assign edit_cur = '{digits: time_q, cursor: cursor_q, setting: setting_q};

  bcdc_editor u_edit (
    .cur_i (edit_cur),
    .key_i (in_item_i.key_code),
    .nxt_o (edit_nxt)
  );

  // output register frees up as soon as its item is taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // prescaler: 8-bit wrap, compare >= so a count of 0 behaves like 1
  assign tick_inc = tick_q + 8'd1;
  assign sec_hit  = (in_item_i.operation == OP_TICK) && !setting_q && (tick_inc >= tps);

  always_comb begin
    time_d    = time_q;
    tick_d    = tick_q;
    cursor_d  = cursor_q;
    setting_d = setting_q;
    if (accept) begin
      if (in_item_i.operation == OP_TICK) begin
        // ticks are dropped while the clock is stopped for setting
        if (!setting_q) begin
          tick_d = sec_hit ? 8'd0 : tick_inc;
          if (sec_hit) begin
            time_d = time_adv;
          end
        end
      end else begin
        time_d    = edit_nxt.digits;
        cursor_d  = edit_nxt.cursor;
        setting_d = edit_nxt.setting;
      end
    end
  end

  always_comb begin
    out_d.sec_units      = time_d.sec_units;
    out_d.sec_tens       = time_d.sec_tens;
    out_d.min_units      = time_d.min_units;
    out_d.min_tens       = time_d.min_tens;
    out_d.hour_units     = time_d.hour_units;
    out_d.hour_tens      = time_d.hour_tens;
    out_d.cursor_pos     = cursor_d;
    out_d.setting_mode   = setting_d;
    out_d.second_elapsed = sec_hit;
    out_valid_d          = accept || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      tick_q      <= 8'd0;
      cursor_q    <= CUR_HOUR_T;
      setting_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      time_q      <= time_d;
      tick_q      <= tick_d;
      cursor_q    <= cursor_d;
      setting_q   <= setting_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---- checks ----
  `ASSERT_CLK(a_set_entry, accept && in_item_i.operation == OP_KEY && !setting_q && in_item_i.key_code == KEY_SET |=> setting_q && cursor_q == CUR_HOUR_T, "set key did not enter set mode at hours tens")
  `ASSERT_CLK(a_tick_frozen, accept && in_item_i.operation == OP_TICK && setting_q |=> $stable(time_q) && $stable(tick_q), "tick changed state in set mode")
  `ASSERT_NEVER(a_elapsed_in_set, out_valid_q && out_q.second_elapsed && out_q.setting_mode, "second elapsed while stopped")
  `ASSERT_NEVER(a_hour_range, time_q.hour_tens == HOUR_T_MAX && time_q.hour_units > HOUR_U_MAX_20, "hour above 23")
  `ASSERT_CLK(a_out_hold, out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q), "held result lost")

endmodule
